// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key/value cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned CAP_W = 5;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned RES_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_ACT,
    ST_EVICT,
    ST_INSERT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic match;
    logic touch;
    logic write_hit;
    logic evict;
    logic insert;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic is_put;
    logic hit;
    logic over_cap;
    logic at_cap;
    logic free_avail;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/lkvc_if.sv
// ----------------------------------------------------------------------------
// lkvc_if
// Request, response and configuration channels of the LRU key/value cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lkvc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key;
  logic [lkvc_pkg::VAL_W-1:0]       store_value;

  modport source (output valid, command, lookup_key, store_value, input ready);
  modport sink   (input valid, command, lookup_key, store_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic signed [lkvc_pkg::RES_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

interface lkvc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lkvc_pkg::CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for one cache item: match, act, evict, insert, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lkvc_pkg::stat_t stat_i,
  output lkvc_pkg::ctrl_t ctrl_o
);

  lkvc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = lkvc_pkg::ST_MATCH;
        end
      end
      lkvc_pkg::ST_MATCH: begin
        ctrl_o.match = 1'b1;
        state_d      = lkvc_pkg::ST_ACT;
      end
      lkvc_pkg::ST_ACT: begin
        if (!stat_i.is_put) begin
          ctrl_o.touch = stat_i.hit;
          state_d      = lkvc_pkg::ST_FINISH;
        end else if (stat_i.hit) begin
          ctrl_o.touch     = 1'b1;
          ctrl_o.write_hit = 1'b1;
          state_d = stat_i.over_cap ? lkvc_pkg::ST_EVICT : lkvc_pkg::ST_FINISH;
        end else begin
          state_d = stat_i.at_cap ? lkvc_pkg::ST_EVICT : lkvc_pkg::ST_INSERT;
        end
      end
      lkvc_pkg::ST_EVICT: begin
        ctrl_o.evict = 1'b1;
        state_d = (stat_i.is_put && !stat_i.hit) ? lkvc_pkg::ST_INSERT
                                                 : lkvc_pkg::ST_FINISH;
      end
      lkvc_pkg::ST_INSERT: begin
        ctrl_o.insert = 1'b1;
        state_d       = lkvc_pkg::ST_FINISH;
      end
      lkvc_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key tags, recency ranks, value memory, capacity register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_command_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0] in_lookup_key_i,
  input  logic [lkvc_pkg::VAL_W-1:0]        in_store_value_i,
  input  logic                              cfg_valid_i,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_found_o,
  output logic signed [lkvc_pkg::RES_W-1:0] out_read_value_o,
  input  lkvc_pkg::ctrl_t                   ctrl_i,
  output lkvc_pkg::stat_t                   stat_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);

  lkvc_pkg::op_e              op_q;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [ENTRIES-1:0]         valid_q;
  logic [lkvc_pkg::KEY_W-1:0] tag_q [ENTRIES];
  logic [IW-1:0]              rank_q [ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] value_mem [ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] rd_val_q;
  logic [LW-1:0]              live_q;
  logic                       hit_q;
  logic [IW-1:0]              hit_idx_q;
  logic                       out_valid_q;
  logic                       out_found_q;
  logic [lkvc_pkg::RES_W-1:0] out_value_q;

  logic          m_hit;
  logic [IW-1:0] m_idx;
  logic          old_found;
  logic [IW-1:0] old_idx;
  logic [IW-1:0] old_rank;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [7:0]    cap_w;
  logic [LW-1:0] eff_cap;
  logic [IW-1:0] hit_rank;
  logic          do_insert;
  logic          do_evict;

  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && tag_q[i] == key_q) begin
        m_hit = 1'b1;
        m_idx = IW'(i);
      end
    end
  end

  assign old_rank = IW'(live_q - LW'(1));

  always_comb begin
    old_found  = 1'b0;
    old_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && rank_q[i] == old_rank) begin
        old_found = 1'b1;
        old_idx   = IW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    cap_w = {3'b000, cap_q};
    if (cap_w == 8'd0) begin
      cap_w = 8'd1;
    end
    if (cap_w > 8'(ENTRIES)) begin
      cap_w = 8'(ENTRIES);
    end
    eff_cap = LW'(cap_w);
  end

  assign hit_rank  = rank_q[hit_idx_q];
  assign do_insert = ctrl_i.insert && free_found;
  assign do_evict  = ctrl_i.evict && (live_q != '0) && old_found;

  assign stat_o.is_put     = (op_q == lkvc_pkg::CMD_PUT);
  assign stat_o.hit        = hit_q;
  assign stat_o.over_cap   = (live_q > eff_cap);
  assign stat_o.at_cap     = (live_q >= eff_cap);
  assign stat_o.free_avail = free_found;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkvc_pkg::CAP_RESET;
      valid_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (do_evict) begin
        valid_q[old_idx] <= 1'b0;
        live_q           <= live_q - LW'(1);
      end else if (do_insert) begin
        valid_q[free_idx] <= 1'b1;
        live_q            <= live_q + LW'(1);
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q  <= lkvc_pkg::op_e'(in_command_i);
      key_q <= in_lookup_key_i;
      val_q <= in_store_value_i;
    end
    if (ctrl_i.match) begin
      hit_q     <= m_hit;
      hit_idx_q <= m_idx;
    end
    if (ctrl_i.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && rank_q[i] < hit_rank) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
      rank_q[hit_idx_q] <= '0;
    end else if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
      rank_q[free_idx] <= '0;
      tag_q[free_idx]  <= key_q;
    end
    if (ctrl_i.load_out) begin
      out_found_q <= hit_q;
      if (op_q == lkvc_pkg::CMD_PUT) begin
        out_value_q <= '0;
      end else if (hit_q) begin
        out_value_q <= {1'b0, rd_val_q};
      end else begin
        out_value_q <= '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_hit) begin
      value_mem[hit_idx_q] <= val_q;
    end else if (do_insert) begin
      value_mem[free_idx] <= val_q;
    end
    rd_val_q <= value_mem[hit_idx_q];
  end

  assign out_valid_o      = out_valid_q;
  assign out_found_o      = out_found_q;
  assign out_read_value_o = out_value_q;

endmodule

// File: hdl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  dir  handshake      payload
//   req      in   valid / ready  command, lookup_key, store_value
//   rsp      out  valid / ready  found, read_value
//   cfg      in   valid / ready  data (capacity)
//
// One item at a time: each item passes the match and act steps of the
// sequencer, then an evict step for a put that hits above capacity or
// misses at capacity, an insert step for a put that misses, then finish.
// Reset empties the store and sets capacity to 16; cfg is always ready.
// A stalled rsp holds its item; the next item is accepted meanwhile and
// waits in its final step until the result register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lkvc_req_if.sink  req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink  cfg
);

  lkvc_pkg::ctrl_t ctrl;
  lkvc_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_command_i     (req.command),
    .in_lookup_key_i  (req.lookup_key),
    .in_store_value_i (req.store_value),
    .cfg_valid_i      (cfg.valid),
    .cfg_data_i       (cfg.data),
    .out_ready_i      (rsp.ready),
    .out_valid_o      (rsp.valid),
    .out_found_o      (rsp.found),
    .out_read_value_o (rsp.read_value),
    .ctrl_i           (ctrl),
    .stat_o           (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while previous item in progress");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |-> stat.free_avail)
    else $error("insert with no free slot");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> stat.out_free)
    else $error("result register overwritten");

  a_rsp_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> $past(ctrl.load_out))
    else $error("response raised without a load");

endmodule
